// ===== hw/rtl/asrc_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and helpers of the aerator staging rotation controller.
// No dependencies; every other file imports this package.

package asrc_pkg;

    localparam int NUM_AERATORS = 4;

    localparam int IDX_W     = (NUM_AERATORS > 1) ? $clog2(NUM_AERATORS) : 1;
    localparam int CNT_W     = $clog2(NUM_AERATORS + 1);
    localparam int K_W       = $clog2(NUM_AERATORS / 2 + 1);
    localparam int MODE_W    = 2;
    localparam int OXY_W     = 16;
    localparam int TIME_W    = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int MASK_W    = 4;
    localparam int RCNT_W    = 3;
    localparam int MASK_KEEP = (NUM_AERATORS < MASK_W) ? NUM_AERATORS : MASK_W;

    typedef logic [MODE_W-1:0]    t_mode;
    typedef logic [OXY_W-1:0]     t_oxy;
    typedef logic [TIME_W-1:0]    t_time;
    typedef logic [CFG_W-1:0]     t_cfg;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [MASK_W-1:0]    t_mask;
    typedef logic [RCNT_W-1:0]    t_rcnt;
    typedef logic [1:0]           t_band;

    localparam t_time MS_PER_MINUTE = 32'd60000;

    localparam t_mode MODE_OFF    = 2'd0;
    localparam t_mode MODE_MANUAL = 2'd1;
    localparam t_mode MODE_AUTO   = 2'd2;

    localparam t_band BAND_LOW  = 2'd0;
    localparam t_band BAND_MID  = 2'd1;
    localparam t_band BAND_HIGH = 2'd2;

    localparam t_cfg_idx CFG_LOWER  = 3'd0;
    localparam t_cfg_idx CFG_UPPER  = 3'd1;
    localparam t_cfg_idx CFG_ADD    = 3'd2;
    localparam t_cfg_idx CFG_ROTATE = 3'd3;
    localparam t_cfg_idx CFG_WARN   = 3'd4;

    localparam t_oxy  RST_LOWER    = 16'd400;
    localparam t_oxy  RST_UPPER    = 16'd600;
    localparam t_time RST_ADD_LIM  = 32'd300000;
    localparam t_time RST_ROT_LIM  = 32'd3600000;
    localparam t_time RST_WARN_LIM = 32'd600000;

    typedef struct packed {
        logic  load_item;
        logic  i2r;
        logic  r2i;
        logic  stamp_add;
        logic  stamp_rot;
        logic  stamp_warn;
        logic  set_warn;
        logic  clr_warn;
        logic  set_band;
        t_band band;
        logic  load_k;
        logic  dec_k;
        logic  load_out;
    } t_cmd;

    typedef struct packed {
        logic is_auto;
        logic low;
        logic high;
        logic run_empty;
        logic run_many;
        logic band_mid;
        logic band_high;
        logic el_add;
        logic el_rot;
        logic el_warn;
        logic k_zero;
    } t_stat;

    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                  input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(a) + (CNT_W+1)'(b);
        if (s >= (CNT_W+1)'(NUM_AERATORS)) begin
            s = s - (CNT_W+1)'(NUM_AERATORS);
        end
        return s[IDX_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/asrc_in_if.sv =====
`timescale 1ns / 1ps
// Input channel of the aerator staging rotation controller: one control word per item.
// Depends on asrc_pkg.

interface asrc_in_if;
    import asrc_pkg::*;

    logic  valid;
    logic  ready;
    t_mode mode;
    t_oxy  oxygen_level;
    t_time now_ms;

    modport source(output valid, mode, oxygen_level, now_ms, input ready);
    modport sink(input valid, mode, oxygen_level, now_ms, output ready);
endinterface

// ===== hw/rtl/asrc_out_if.sv =====
`timescale 1ns / 1ps
// Output channel of the aerator staging rotation controller: one status word per item.
// Depends on asrc_pkg.

interface asrc_out_if;
    import asrc_pkg::*;

    logic  valid;
    logic  ready;
    t_mask aerator_on_mask;
    t_rcnt running_count;
    logic  warning_on;

    modport source(output valid, aerator_on_mask, running_count, warning_on, input ready);
    modport sink(input valid, aerator_on_mask, running_count, warning_on, output ready);
endinterface

// ===== hw/rtl/aerator_staging_rotation_controller.sv =====
`timescale 1ns / 1ps
// Top level of the aerator staging rotation controller.
// Depends on asrc_pkg, asrc_in_if, asrc_out_if, asrc_ctrl and asrc_dp.
//
// Usage:
//   i_in  takes one control word per evaluation: mode, oxygen_level, now_ms.
//   o_out returns one status word per control word: aerator_on_mask,
//         running_count and warning_on, in order.
//   Both channels move a word at a rising edge with valid and ready high.
//   The configuration port writes thresholds and the add, rotate and
//   warning periods (in minutes) at any edge with i_cfg_we high; write it
//   only while no word is in flight. Unknown indices are ignored.
// Sequencing and throughput:
//   A word passes through evaluation, the threshold check, any shrinking,
//   rotation or draining of the group, the warning step and the output
//   load; the queues move one aerator per cycle.
//   One word is in work at a time; the next is taken once the block is back in idle.
// Reset: all aerators idle in index order, timers and warning cleared,
//   thresholds and periods at their defaults.
// Stall: a finished word holds in the output register; the next word is
//   accepted and worked meanwhile, and waits at its end until o_out drains.

module aerator_staging_rotation_controller (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  asrc_pkg::t_cfg_idx i_cfg_idx,
    input  asrc_pkg::t_cfg     i_cfg_data,
    asrc_in_if.sink            i_in,
    asrc_out_if.source         o_out
);
    import asrc_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    asrc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    asrc_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_mode     (i_in.mode),
        .i_oxy      (i_in.oxygen_level),
        .i_now      (i_in.now_ms),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_mask     (o_out.aerator_on_mask),
        .o_rcnt     (o_out.running_count),
        .o_warn     (o_out.warning_on)
    );

endmodule

// ===== hw/rtl/asrc_dp.sv =====
`timescale 1ns / 1ps
// Datapath: configuration registers, run and idle queues, timers, band phase and result word.
// Depends on asrc_pkg; driven by asrc_ctrl through t_cmd, reports through t_stat.

module asrc_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  asrc_pkg::t_cfg_idx i_cfg_idx,
    input  asrc_pkg::t_cfg     i_cfg_data,
    input  asrc_pkg::t_mode    i_mode,
    input  asrc_pkg::t_oxy     i_oxy,
    input  asrc_pkg::t_time    i_now,
    input  asrc_pkg::t_cmd     i_cmd,
    output asrc_pkg::t_stat    o_stat,
    output asrc_pkg::t_mask    o_mask,
    output asrc_pkg::t_rcnt    o_rcnt,
    output logic               o_warn
);
    import asrc_pkg::*;

    t_oxy  r_lower, r_upper;
    t_time r_add_lim, r_rot_lim, r_warn_lim;
    t_time n_lim;

    t_mode r_mode;
    t_oxy  r_oxy;
    t_time r_now;

    logic [IDX_W-1:0]        r_run_slot  [NUM_AERATORS];
    logic [IDX_W-1:0]        r_idle_slot [NUM_AERATORS];
    logic [IDX_W-1:0]        r_run_head, r_idle_head;
    logic [CNT_W-1:0]        r_run_cnt, r_idle_cnt;
    logic [NUM_AERATORS-1:0] r_run_mask;
    logic [IDX_W-1:0]        w_idle_out, w_run_out;

    t_time            r_add_stamp, r_rot_stamp, r_warn_stamp;
    t_band            r_band;
    logic             r_warn_flag;
    logic [K_W-1:0]   r_k;
    logic [K_W-1:0]   n_k;

    t_mask r_out_mask;
    t_rcnt r_out_rcnt;
    logic  r_out_warn;

    assign n_lim = TIME_W'(i_cfg_data) * MS_PER_MINUTE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower    <= RST_LOWER;
            r_upper    <= RST_UPPER;
            r_add_lim  <= RST_ADD_LIM;
            r_rot_lim  <= RST_ROT_LIM;
            r_warn_lim <= RST_WARN_LIM;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LOWER:  r_lower    <= i_cfg_data;
                CFG_UPPER:  r_upper    <= i_cfg_data;
                CFG_ADD:    r_add_lim  <= n_lim;
                CFG_ROTATE: r_rot_lim  <= n_lim;
                CFG_WARN:   r_warn_lim <= n_lim;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_mode <= i_mode;
            r_oxy  <= i_oxy;
            r_now  <= i_now;
        end
    end

    assign w_idle_out = r_idle_slot[r_idle_head];
    assign w_run_out  = r_run_slot[r_run_head];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_head  <= '0;
            r_run_cnt   <= '0;
            r_idle_head <= '0;
            r_idle_cnt  <= CNT_W'(NUM_AERATORS);
            r_run_mask  <= '0;
            for (int i = 0; i < NUM_AERATORS; i++) begin
                r_idle_slot[i] <= IDX_W'(i);
            end
        end else if (i_cmd.i2r && r_idle_cnt != '0) begin
            r_idle_head                             <= wrap_add(r_idle_head, CNT_W'(1));
            r_idle_cnt                              <= r_idle_cnt - CNT_W'(1);
            r_run_slot[wrap_add(r_run_head, r_run_cnt)] <= w_idle_out;
            r_run_cnt                               <= r_run_cnt + CNT_W'(1);
            r_run_mask[w_idle_out]                  <= 1'b1;
        end else if (i_cmd.r2i && r_run_cnt != '0) begin
            r_run_head                                    <= wrap_add(r_run_head, CNT_W'(1));
            r_run_cnt                                     <= r_run_cnt - CNT_W'(1);
            r_idle_slot[wrap_add(r_idle_head, r_idle_cnt)] <= w_run_out;
            r_idle_cnt                                    <= r_idle_cnt + CNT_W'(1);
            r_run_mask[w_run_out]                         <= 1'b0;
        end
    end

    assign n_k = (r_run_cnt > CNT_W'(NUM_AERATORS / 2))
               ? K_W'(CNT_W'(NUM_AERATORS) - r_run_cnt)
               : K_W'(r_run_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_add_stamp  <= '0;
            r_rot_stamp  <= '0;
            r_warn_stamp <= '0;
            r_band       <= BAND_LOW;
            r_warn_flag  <= 1'b0;
            r_k          <= '0;
        end else begin
            if (i_cmd.stamp_add) begin
                r_add_stamp <= r_now;
            end
            if (i_cmd.stamp_rot) begin
                r_rot_stamp <= r_now;
            end
            if (i_cmd.stamp_warn) begin
                r_warn_stamp <= r_now;
            end
            if (i_cmd.set_band) begin
                r_band <= i_cmd.band;
            end
            if (i_cmd.set_warn) begin
                r_warn_flag <= 1'b1;
            end else if (i_cmd.clr_warn) begin
                r_warn_flag <= 1'b0;
            end
            if (i_cmd.load_k) begin
                r_k <= n_k;
            end else if (i_cmd.dec_k) begin
                r_k <= r_k - K_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_mask <= MASK_W'(r_run_mask[MASK_KEEP-1:0]);
            r_out_rcnt <= RCNT_W'(r_run_cnt);
            r_out_warn <= r_warn_flag;
        end
    end

    always_comb begin
        o_stat.is_auto   = (r_mode == MODE_AUTO);
        o_stat.low       = (r_oxy < r_lower);
        o_stat.high      = (r_oxy > r_upper);
        o_stat.run_empty = (r_run_cnt == '0);
        o_stat.run_many  = (r_run_cnt > CNT_W'(1));
        o_stat.band_mid  = (r_band == BAND_MID);
        o_stat.band_high = (r_band == BAND_HIGH);
        o_stat.el_add    = ((r_now - r_add_stamp) > r_add_lim);
        o_stat.el_rot    = ((r_now - r_rot_stamp) > r_rot_lim);
        o_stat.el_warn   = ((r_now - r_warn_stamp) > r_warn_lim);
        o_stat.k_zero    = (r_k == '0);
    end

    assign o_mask = r_out_mask;
    assign o_rcnt = r_out_rcnt;
    assign o_warn = r_out_warn;

`ifndef SYNTHESIS
    a_conserve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CNT_W+1)'(r_run_cnt) + (CNT_W+1)'(r_idle_cnt) == (CNT_W+1)'(NUM_AERATORS))
        else $error("aerator lost or duplicated between queues");
    a_mask_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_run_mask) == int'(r_run_cnt))
        else $error("run mask disagrees with run count");
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.i2r && r_idle_cnt != '0) |=> r_run_cnt == $past(r_run_cnt) + CNT_W'(1))
        else $error("start did not grow the run queue");
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_k |=> (r_k <= K_W'(NUM_AERATORS / 2)))
        else $error("rotation count beyond half the group");
`endif

endmodule

// ===== hw/rtl/asrc_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences one item through staging, rotation and warning steps.
// Depends on asrc_pkg; commands asrc_dp through t_cmd and reads t_stat.

module asrc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  asrc_pkg::t_stat i_stat,
    output asrc_pkg::t_cmd  o_cmd
);
    import asrc_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_EVAL    = 4'd1;
    localparam logic [3:0] S_CHECK   = 4'd2;
    localparam logic [3:0] S_SHRINK  = 4'd3;
    localparam logic [3:0] S_ROT_IN  = 4'd4;
    localparam logic [3:0] S_ROT_OUT = 4'd5;
    localparam logic [3:0] S_DRAIN   = 4'd6;
    localparam logic [3:0] S_WARN    = 4'd7;
    localparam logic [3:0] S_DONE    = 4'd8;

    logic [3:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_EVAL;
                end
            end
            S_EVAL: begin
                if (!i_stat.is_auto) begin
                    n_state = S_DRAIN;
                end else begin
                    if (i_stat.run_empty) begin
                        o_cmd.i2r       = 1'b1;
                        o_cmd.stamp_add = 1'b1;
                        o_cmd.stamp_rot = 1'b1;
                    end
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.low) begin
                    if (i_stat.el_add) begin
                        o_cmd.i2r       = 1'b1;
                        o_cmd.stamp_add = 1'b1;
                    end
                    o_cmd.set_band = 1'b1;
                    o_cmd.band     = BAND_LOW;
                    n_state        = S_WARN;
                end else if (i_stat.high) begin
                    n_state = S_SHRINK;
                end else if (i_stat.band_mid) begin
                    if (i_stat.el_rot) begin
                        o_cmd.load_k    = 1'b1;
                        o_cmd.stamp_rot = 1'b1;
                        n_state         = S_ROT_IN;
                    end else begin
                        n_state = S_WARN;
                    end
                end else begin
                    o_cmd.set_band  = 1'b1;
                    o_cmd.band      = BAND_MID;
                    o_cmd.stamp_rot = 1'b1;
                    n_state         = S_WARN;
                end
            end
            S_SHRINK: begin
                if (i_stat.run_many) begin
                    o_cmd.r2i = 1'b1;
                end else if (i_stat.band_high) begin
                    if (i_stat.el_rot) begin
                        o_cmd.load_k    = 1'b1;
                        o_cmd.stamp_rot = 1'b1;
                        n_state         = S_ROT_IN;
                    end else begin
                        n_state = S_WARN;
                    end
                end else begin
                    o_cmd.set_band  = 1'b1;
                    o_cmd.band      = BAND_HIGH;
                    o_cmd.stamp_rot = 1'b1;
                    n_state         = S_WARN;
                end
            end
            S_ROT_IN: begin
                if (i_stat.k_zero) begin
                    n_state = S_WARN;
                end else begin
                    o_cmd.i2r = 1'b1;
                    n_state   = S_ROT_OUT;
                end
            end
            S_ROT_OUT: begin
                o_cmd.r2i   = 1'b1;
                o_cmd.dec_k = 1'b1;
                n_state     = S_ROT_IN;
            end
            S_DRAIN: begin
                if (!i_stat.run_empty) begin
                    o_cmd.r2i = 1'b1;
                end else begin
                    n_state = S_WARN;
                end
            end
            S_WARN: begin
                if (i_stat.low) begin
                    if (i_stat.el_warn) begin
                        o_cmd.set_warn   = 1'b1;
                        o_cmd.stamp_warn = 1'b1;
                    end
                end else begin
                    o_cmd.clr_warn   = 1'b1;
                    o_cmd.stamp_warn = 1'b1;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== verif/asrc_status_checker.sv =====
`timescale 1ns / 1ps
// Checker for the aerator staging rotation controller: mirrors the run and idle queues,
// the timers and the warning, predicts each status word and compares it at o_out.
// Depends on asrc_pkg, asrc_in_if and asrc_out_if.

module asrc_status_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  asrc_pkg::t_cfg_idx i_cfg_idx,
    input  asrc_pkg::t_cfg     i_cfg_data,
    asrc_in_if                 in_ch,
    asrc_out_if                out_ch,
    output int                 o_fail_count,
    output int                 o_pending
);
    import asrc_pkg::*;

    localparam int PRINT_CAP = 40;

    typedef logic [IDX_W-1:0] t_aer_idx;

    typedef struct packed {
        t_mask mask;
        t_rcnt count;
        logic  warn;
    } t_status;

    t_aer_idx run_q[$];
    t_aer_idx idle_q[$];
    t_status  status_q[$];

    t_oxy  lower_thr;
    t_oxy  upper_thr;
    t_cfg  add_min;
    t_cfg  rot_min;
    t_cfg  warn_min;
    t_time add_stamp;
    t_time rot_stamp;
    t_time warn_stamp;
    t_band band_state;
    logic  warn_flag;

    int fail_count = 0;
    int pending_words = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_words;

    function automatic void reset_group();
        run_q.delete();
        idle_q.delete();
        for (int i = 0; i < NUM_AERATORS; i++) begin
            idle_q.push_back(t_aer_idx'(i));
        end
        lower_thr  = RST_LOWER;
        upper_thr  = RST_UPPER;
        add_min    = t_cfg'(RST_ADD_LIM / MS_PER_MINUTE);
        rot_min    = t_cfg'(RST_ROT_LIM / MS_PER_MINUTE);
        warn_min   = t_cfg'(RST_WARN_LIM / MS_PER_MINUTE);
        add_stamp  = '0;
        rot_stamp  = '0;
        warn_stamp = '0;
        band_state = BAND_LOW;
        warn_flag  = 1'b0;
    endfunction

    function automatic void move_idle_to_run();
        if (idle_q.size() != 0) begin
            run_q.push_back(idle_q.pop_front());
        end
    endfunction

    function automatic void move_run_to_idle();
        if (run_q.size() != 0) begin
            idle_q.push_back(run_q.pop_front());
        end
    endfunction

    function automatic bit period_over(t_time now, t_time stamp, t_cfg minutes);
        t_time lim;
        t_time diff;
        lim  = t_time'(minutes) * MS_PER_MINUTE;
        diff = now - stamp;
        return diff > lim;
    endfunction

    function automatic void rotate_group();
        int k;
        k = run_q.size();
        if (k > NUM_AERATORS / 2) begin
            k = NUM_AERATORS - k;
        end
        repeat (k) begin
            move_idle_to_run();
            move_run_to_idle();
        end
    endfunction

    function automatic t_status predict_status(t_mode mode, t_oxy oxy, t_time now);
        t_status s;
        s = '0;
        if (mode == MODE_AUTO) begin
            if (run_q.size() == 0) begin
                move_idle_to_run();
                add_stamp = now;
                rot_stamp = now;
            end
            if (oxy < lower_thr) begin
                if (period_over(now, add_stamp, add_min)) begin
                    move_idle_to_run();
                    add_stamp = now;
                end
                band_state = BAND_LOW;
            end else if (oxy > upper_thr) begin
                while (run_q.size() > 1) begin
                    move_run_to_idle();
                end
                if (band_state == BAND_HIGH) begin
                    if (period_over(now, rot_stamp, rot_min)) begin
                        rotate_group();
                        rot_stamp = now;
                    end
                end else begin
                    band_state = BAND_HIGH;
                    rot_stamp  = now;
                end
            end else begin
                warn_flag = 1'b0;
                if (band_state == BAND_MID) begin
                    if (period_over(now, rot_stamp, rot_min)) begin
                        rotate_group();
                        rot_stamp = now;
                    end
                end else begin
                    band_state = BAND_MID;
                    rot_stamp  = now;
                end
            end
        end else begin
            while (run_q.size() > 0) begin
                move_run_to_idle();
            end
        end

        if (oxy < lower_thr) begin
            if (period_over(now, warn_stamp, warn_min)) begin
                warn_flag  = 1'b1;
                warn_stamp = now;
            end
        end else begin
            warn_stamp = now;
            warn_flag  = 1'b0;
        end

        foreach (run_q[i]) begin
            if (int'(run_q[i]) < MASK_W) begin
                s.mask[run_q[i]] = 1'b1;
            end
        end
        s.count = t_rcnt'(run_q.size());
        s.warn  = warn_flag;
        return s;
    endfunction

    task automatic report_mismatch(string what);
        if (fail_count < PRINT_CAP) begin
            $display("%0t asrc_status_checker: %s", $time, what);
        end
        fail_count++;
    endtask

    always @(posedge i_clk) begin : watch
        t_status want;
        if (!i_rst_n) begin
            reset_group();
            status_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LOWER:  lower_thr = i_cfg_data;
                    CFG_UPPER:  upper_thr = i_cfg_data;
                    CFG_ADD:    add_min   = i_cfg_data;
                    CFG_ROTATE: rot_min   = i_cfg_data;
                    CFG_WARN:   warn_min  = i_cfg_data;
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready) begin
                if (status_q.size() == 0) begin
                    report_mismatch("status word with none expected");
                end else begin
                    want = status_q.pop_front();
                    if (out_ch.aerator_on_mask !== want.mask) begin
                        report_mismatch($sformatf("aerator_on_mask got %h, expected %h",
                                                  out_ch.aerator_on_mask, want.mask));
                    end
                    if (out_ch.running_count !== want.count) begin
                        report_mismatch($sformatf("running_count got %0d, expected %0d",
                                                  out_ch.running_count, want.count));
                    end
                    if (out_ch.warning_on !== want.warn) begin
                        report_mismatch($sformatf("warning_on got %b, expected %b",
                                                  out_ch.warning_on, want.warn));
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                status_q.push_back(predict_status(in_ch.mode, in_ch.oxygen_level,
                                                  in_ch.now_ms));
            end
        end
        pending_words = status_q.size();
    end

endmodule

// ===== verif/aerator_staging_rotation_controller_tb.sv =====
`timescale 1ns / 1ps
// Testbench top of the aerator staging rotation controller: clock, reset, register
// writes and control words with random gaps and stalls; the verdict comes from asrc_status_checker.
// Depends on asrc_pkg, asrc_in_if, asrc_out_if, asrc_status_checker and the block itself.

module aerator_staging_rotation_controller_tb;
    import asrc_pkg::*;

    localparam int    CYCLE_LIMIT  = 600000;
    localparam int    DRAIN_CYCLES = 2 * NUM_AERATORS + 20;
    localparam t_mode MODE_SPARE   = 2'd3;

    localparam int CLS_LOW  = 0;
    localparam int CLS_BAND = 1;
    localparam int CLS_HIGH = 2;
    localparam int CLS_EDGE = 3;
    localparam int CLS_ANY  = 4;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     cfg_we  = 1'b0;
    t_cfg_idx cfg_idx = CFG_LOWER;
    t_cfg     cfg_data = '0;

    int    fail_count;
    int    pending_words;
    int    cycle_count = 0;
    int    idle_pct = 16;
    int    oxy_cls = CLS_BAND;
    t_oxy  cur_lower = RST_LOWER;
    t_oxy  cur_upper = RST_UPPER;
    t_time sim_ms = '0;

    asrc_in_if  in_ch ();
    asrc_out_if out_ch ();

    aerator_staging_rotation_controller dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    asrc_status_checker status_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_words)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("aerator_staging_rotation_controller_tb: FAIL");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= idle_pct);
    end

    task automatic send_word(t_mode mode, t_oxy oxy, t_time now);
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.mode         <= mode;
        in_ch.oxygen_level <= oxy;
        in_ch.now_ms       <= now;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending_words != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_config(t_oxy lo, t_oxy up, t_cfg add_m, t_cfg rot_m, t_cfg warn_m,
                              bit spare);
        t_cfg vals[5];
        vals = '{lo, up, add_m, rot_m, warn_m};
        for (int i = 0; i < 5; i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= t_cfg_idx'(int'(CFG_LOWER) + i);
            cfg_data <= vals[i];
            @(negedge i_clk);
        end
        if (spare) begin
            for (int s = int'(CFG_WARN) + 1; s < (1 << CFG_IDX_W); s++) begin
                cfg_idx  <= t_cfg_idx'(s);
                cfg_data <= t_cfg'($urandom);
                @(negedge i_clk);
            end
        end
        cfg_we    <= 1'b0;
        cur_lower = lo;
        cur_upper = up;
        @(negedge i_clk);
    endtask

    function automatic t_oxy pick_oxy(int cls);
        int lo;
        int up;
        lo = cur_lower;
        up = cur_upper;
        case (cls)
            CLS_LOW: begin
                if (lo == 0) return t_oxy'($urandom);
                return t_oxy'($urandom_range(lo - 1, 0));
            end
            CLS_BAND: begin
                if (lo > up) return t_oxy'($urandom);
                return t_oxy'($urandom_range(up, lo));
            end
            CLS_HIGH: begin
                if (up == 65535) return t_oxy'($urandom);
                return t_oxy'($urandom_range(65535, up + 1));
            end
            CLS_EDGE: begin
                case ($urandom_range(3))
                    0: return t_oxy'(lo - 1);
                    1: return t_oxy'(lo);
                    2: return t_oxy'(up);
                    default: return t_oxy'(up + 1);
                endcase
            end
            default: return t_oxy'($urandom);
        endcase
    endfunction

    // Hold the oxygen class for a while so that the timers get to run out.
    task automatic run_phase(int n_words, int unsigned step_max, bit hold_mid);
        t_mode mode;
        for (int i = 0; i < n_words; i++) begin
            if (hold_mid && i == n_words / 2) begin
                wait_drained();
            end
            if ($urandom_range(99) >= 85) begin
                oxy_cls = $urandom_range(CLS_ANY, CLS_LOW);
            end
            if ($urandom_range(99) < 80) begin
                mode = MODE_AUTO;
            end else begin
                mode = t_mode'($urandom_range(3));
            end
            if ($urandom_range(99) < 3) begin
                sim_ms = $urandom;
            end else begin
                sim_ms = sim_ms + $urandom_range(step_max, 0);
            end
            send_word(mode, pick_oxy(oxy_cls), sim_ms);
        end
        wait_drained();
    endtask

    initial begin : stimulus
        in_ch.valid        = 1'b0;
        in_ch.mode         = MODE_OFF;
        in_ch.oxygen_level = '0;
        in_ch.now_ms       = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_word(MODE_AUTO,   16'd500,   32'd0);
        send_word(MODE_AUTO,   16'd500,   32'd3600001);
        send_word(MODE_AUTO,   16'd399,   32'd3600002);
        send_word(MODE_AUTO,   16'd0,     32'd3900002);
        send_word(MODE_AUTO,   16'd0,     32'd3900003);
        send_word(MODE_AUTO,   16'd0,     32'd4200004);
        send_word(MODE_AUTO,   16'd0,     32'd4500005);
        send_word(MODE_AUTO,   16'd400,   32'd4500006);
        send_word(MODE_AUTO,   16'd600,   32'd8100007);
        send_word(MODE_AUTO,   16'd65535, 32'd8100008);
        send_word(MODE_AUTO,   16'd601,   32'd11700009);
        send_word(MODE_AUTO,   16'd100,   32'd12000010);
        send_word(MODE_AUTO,   16'd100,   32'd12300011);
        send_word(MODE_AUTO,   16'd500,   32'd12300012);
        send_word(MODE_AUTO,   16'd500,   32'd15900013);
        send_word(MODE_MANUAL, 16'd100,   32'd15900014);
        send_word(MODE_MANUAL, 16'd100,   32'd16500015);
        send_word(MODE_AUTO,   16'd100,   32'd16500016);
        send_word(MODE_SPARE,  16'd65535, 32'd16500017);
        send_word(MODE_AUTO,   16'd500,   32'hFFFF_FFFF);
        send_word(MODE_OFF,    16'd0,     32'hFFFF_FFFF);
        send_word(MODE_AUTO,   16'd500,   32'd0);
        sim_ms = '0;
        wait_drained();

        run_phase(200, 400000, 1'b0);

        set_config(16'd1000, 16'd2000, 16'd1, 16'd2, 16'd1, 1'b1);
        run_phase(250, 90000, 1'b1);

        idle_pct = 0;
        set_config(16'd300, 16'd300, 16'd0, 16'd0, 16'd0, 1'b0);
        run_phase(200, 3, 1'b0);
        idle_pct = 16;

        set_config(16'd5000, 16'd1000, 16'd3, 16'd1, 16'd2, 1'b0);
        run_phase(150, 150000, 1'b0);

        set_config(16'd0, 16'd65535, 16'd35791, 16'd35791, 16'd35791, 1'b0);
        sim_ms = 32'hF000_0000;
        run_phase(100, 32'h4000_0000, 1'b0);

        set_config(16'd65535, 16'd0, 16'd65535, 16'd65535, 16'd65535, 1'b1);
        run_phase(100, 32'hFFFF_FFFF, 1'b0);

        set_config(16'd200, 16'd800, 16'd2, 16'd4, 16'd3, 1'b0);
        run_phase(250, 150000, 1'b1);

        if (fail_count == 0 && pending_words == 0) begin
            $display("aerator_staging_rotation_controller_tb: PASS");
        end else begin
            $display("aerator_staging_rotation_controller_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/asrc_pkg.sv
hw/rtl/asrc_in_if.sv
hw/rtl/asrc_out_if.sv
hw/rtl/asrc_dp.sv
hw/rtl/asrc_ctrl.sv
hw/rtl/aerator_staging_rotation_controller.sv
verif/asrc_status_checker.sv
verif/aerator_staging_rotation_controller_tb.sv
